[hw/rtl/rss_pkg.sv]
package rss_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int FIELD_W = 16;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [FIELD_W-1:0] weight;
		logic [FIELD_W-1:0] cost;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		logic keep;
		logic last;
		logic ovf;
		rec_t rec;
	} cmd_t;

endpackage

[hw/rtl/rss_ram.sv]
module rss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/rss_front.sv]
module rss_front #(
	parameter int MAX_ITEMS = rss_pkg::MAX_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [rss_pkg::FIELD_W-1:0] weight,
	input  logic [rss_pkg::FIELD_W-1:0] cost,
	input  logic                        last_item,
	output rss_pkg::cmd_t               cmd
);

	import rss_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             drop_q;
	logic             keep;

	assign keep = (cnt_q < CNT_W'(MAX_ITEMS));

	always_comb begin
		cmd.keep = keep;
		cmd.last = last_item;
		cmd.ovf = drop_q | ~keep;
		cmd.rec.weight = weight;
		cmd.rec.cost = cost;
	end

	// The front counts kept records per set so each request leaves already classified.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (last_item) begin
				cnt_q <= '0;
				drop_q <= 1'b0;
			end else if (keep) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

endmodule

[hw/rtl/rss_queue.sv]
module rss_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rss_pkg::cmd_t push_cmd,
	input  logic          pop,
	output rss_pkg::cmd_t head_cmd,
	output logic          empty,
	output logic          full
);

	import rss_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign empty = (level_q == '0);
	assign full = (level_q == LVL_W'(QUEUE_DEPTH));
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/rss_back.sv]
module rss_back #(
	parameter int MAX_ITEMS = rss_pkg::MAX_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rss_pkg::cmd_t               head_cmd,
	input  logic                        empty,
	output logic                        pop,
	output logic                        strobe,
	output logic [rss_pkg::FIELD_W-1:0] sorted_weight,
	output logic [rss_pkg::FIELD_W-1:0] sorted_cost,
	output logic                        end_of_run,
	output logic                        overflowed
);

	import rss_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int ADDR_W = $clog2(MAX_ITEMS);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_WR_I  = 3'd3;
	localparam logic [2:0] ST_WR_P  = 3'd4;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  n_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] k_q;
	logic [ADDR_W-1:0] pick_q;
	rec_t              min_q;
	rec_t              reci_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic [ADDR_W-1:0] last_idx;
	logic              pass_done;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	rec_t              ram_wdata;
	logic [REC_W-1:0]  ram_rdata;
	rec_t              rd_rec;

	logic              res_vld_q;
	rec_t              res_q;
	logic              res_eor_q;
	logic              res_ovf_q;

	assign last_idx = ADDR_W'(n_q - CNT_W'(1));
	assign pass_done = (i_q == last_idx);
	assign rd_rec = rec_t'(ram_rdata);
	assign pop = (state_q == ST_LOAD) && !empty;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = fill_q[ADDR_W-1:0];
		ram_wdata = head_cmd.rec;
		unique case (state_q)
			ST_LOAD: begin
				ram_we = pop && head_cmd.keep;
			end
			ST_WR_I: begin
				ram_we = (pick_q != i_q);
				ram_waddr = i_q;
				ram_wdata = min_q;
			end
			ST_WR_P: begin
				ram_we = 1'b1;
				ram_waddr = pick_q;
				ram_wdata = reci_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	rss_ram #(
		.WIDTH(REC_W),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(k_q),
		.rdata(ram_rdata)
	);

	// Running minimum of the current pass; a strict compare keeps the first minimum.
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_idx_s1 == i_q) begin
				min_q <= rd_rec;
				reci_q <= rd_rec;
				pick_q <= rd_idx_s1;
			end else if (rd_rec.weight < min_q.weight) begin
				min_q <= rd_rec;
				pick_q <= rd_idx_s1;
			end
		end
		rd_idx_s1 <= k_q;
		if (state_q == ST_WR_I) begin
			res_q <= min_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q <= '0;
			n_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			k_q <= '0;
			rd_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
			res_eor_q <= 1'b0;
			res_ovf_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			res_vld_q <= (state_q == ST_WR_I);
			res_eor_q <= (state_q == ST_WR_I) && pass_done;
			if (state_q == ST_WR_I) begin
				res_ovf_q <= ovf_q;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (head_cmd.last) begin
							n_q <= head_cmd.keep ? fill_q + 1'b1 : fill_q;
							ovf_q <= head_cmd.ovf;
							fill_q <= '0;
							i_q <= '0;
							k_q <= '0;
							state_q <= ST_SCAN;
						end else if (head_cmd.keep) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (k_q == last_idx) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WR_I;
				end
				ST_WR_I, ST_WR_P: begin
					if ((state_q == ST_WR_I) && (pick_q != i_q)) begin
						state_q <= ST_WR_P;
					end else if (pass_done) begin
						state_q <= ST_LOAD;
					end else begin
						i_q <= i_q + 1'b1;
						k_q <= i_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign strobe = res_vld_q;
	assign sorted_weight = res_q.weight;
	assign sorted_cost = res_q.cost;
	assign end_of_run = res_eor_q;
	assign overflowed = res_ovf_q;

endmodule

[hw/rtl/record_selection_sort_top.sv]
// Channel   Direction  Handshake                  Payload
// request   in         start high, busy low       weight, cost, last_item
// result    out        strobe, one cycle, no stall sorted_weight, sorted_cost,
//                                                  end_of_run, overflowed
//
// Each request is taken into a two-entry queue and, if kept, written to the record memory
// when the back pops it while loading. A set of n records is then sorted by one comparator
// that scans through the single memory read port. Sorted position i is shown on strobe
// the cycle after the write-back state for position i.
// busy is high while the queue is full, which happens when requests keep arriving during a sort.
// Reset clears all control state; the record memory is not cleared.
module record_selection_sort_top #(
	parameter int MAX_ITEMS = rss_pkg::MAX_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rss_pkg::FIELD_W-1:0] weight,
	input  logic [rss_pkg::FIELD_W-1:0] cost,
	input  logic                        last_item,
	output logic                        strobe,
	output logic [rss_pkg::FIELD_W-1:0] sorted_weight,
	output logic [rss_pkg::FIELD_W-1:0] sorted_cost,
	output logic                        end_of_run,
	output logic                        overflowed
);

	import rss_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic accept;
	logic q_full;
	logic q_empty;
	logic q_pop;

	assign busy = q_full;
	assign accept = start && !q_full;

	rss_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.weight   (weight),
		.cost     (cost),
		.last_item(last_item),
		.cmd      (front_cmd)
	);

	rss_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.push_cmd(front_cmd),
		.pop     (q_pop),
		.head_cmd(head_cmd),
		.empty   (q_empty),
		.full    (q_full)
	);

	rss_back #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_cmd     (head_cmd),
		.empty        (q_empty),
		.pop          (q_pop),
		.strobe       (strobe),
		.sorted_weight(sorted_weight),
		.sorted_cost  (sorted_cost),
		.end_of_run   (end_of_run),
		.overflowed   (overflowed)
	);

endmodule

[hw/rtl/rss_checker.sv]
module rss_checker (
	input logic clk,
	input logic arst_n,
	input logic strobe,
	input logic end_of_run
);

	// A result marks the end of a run only together with its strobe.
	a_eor_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		end_of_run |-> strobe)
		else $error("end_of_run without strobe");

	// Each sorted position needs a fresh scan, so results never come back to back.
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("strobe on two consecutive cycles");

	// Reset keeps the result side quiet.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> (!strobe && !end_of_run))
		else $error("result shown during reset");

endmodule

bind record_selection_sort_top rss_checker u_rss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.strobe    (strobe),
	.end_of_run(end_of_run)
);
